// ===== sv/dhsh_pkg.sv =====
package dhsh_pkg;

    localparam int HistDays = 8;
    localparam int IdxW = $clog2(HistDays);
    localparam int CntW = $clog2(HistDays + 1);

    localparam logic [2:0] REQ_ENSURE = 3'd0;
    localparam logic [2:0] REQ_STEPS  = 3'd1;
    localparam logic [2:0] REQ_HEART  = 3'd2;
    localparam logic [2:0] REQ_ENV    = 3'd3;
    localparam logic [2:0] REQ_SPORT  = 3'd4;
    localparam logic [2:0] REQ_READ   = 3'd5;

    localparam logic [1:0] ST_UNCHANGED = 2'd0;
    localparam logic [1:0] ST_ROLLED    = 2'd1;
    localparam logic [1:0] ST_INIT      = 2'd2;

    localparam logic CFG_HR_LOW  = 1'b0;
    localparam logic CFG_HR_HIGH = 1'b1;

    // one history entry
    typedef struct packed {
        logic [31:0] day_code;
        logic [15:0] steps;
        logic [7:0]  avg_hr;
        logic [7:0]  max_hr;
        logic [15:0] hr_cnt;
        logic [7:0]  mean_temp;
        logic [7:0]  avg_hum;
        logic [15:0] env_cnt;
        logic [7:0]  sessions;
        logic [15:0] minutes;
    } t_entry;

    // divider control
    typedef struct packed {
        logic        start;
        logic [24:0] dividend;
        logic [16:0] divisor;
    } t_div_req;

endpackage

// ===== sv/dhsh_divider.sv =====
module dhsh_divider
    import dhsh_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_div_req    i_req,
    output logic        o_done,
    output logic [24:0] o_quot
);

    logic [24:0] r_quot;
    logic [17:0] r_rem;
    logic [16:0] r_div;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [17:0] n_rem;
    logic [17:0] n_diff;

    // one quotient bit per cycle, restoring
    always_comb begin
        n_rem  = {r_rem[16:0], r_quot[24]};
        n_diff = n_rem - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd24;
                r_quot <= i_req.dividend;
                r_rem  <= '0;
                r_div  <= i_req.divisor;
            end else if (r_busy) begin
                if (!n_diff[17]) begin
                    r_rem  <= n_diff;
                    r_quot <= {r_quot[23:0], 1'b1};
                end else begin
                    r_rem  <= n_rem;
                    r_quot <= {r_quot[23:0], 1'b0};
                end
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ===== sv/daily_health_summary_history_core.sv =====
// channel   | dir | tdata fields (low bit up)
// s_axis    | in  | req_type..read_index, 80 bits in 80
// m_axis    | out | day_state..entry_sport_minutes, 127 bits in 128
// cfg       | in  | index 0 hr_low_limit, 1 hr_high_limit
// ensure, steps, read and unused items go from the roll step in S_OPEN to S_REPORT, where the result is loaded.
// heart-rate, sport and environment items wait in S_DIV1/S_DIV2 on the shared
// 25-step serial divider, run twice for environment items; out-of-range heart rates and saturated counts skip it.
// the next accept is possible in the cycle after the result is loaded.
// reset empties the history count and restores the limits to 40 and 220.
// a held result leaves the input open for one more transaction, which then waits.
module daily_health_summary_history_core
    import dhsh_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // req_type, year, month, day_of_month, day_of_week, step_total, heart_rate,
    // temperature, humidity_pct, session_seconds, read_index
    input  logic [79:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // day_state, entries_held, entry_valid, entry_day_code, entry_steps, entry_avg_hr,
    // entry_max_hr, entry_hr_count, entry_avg_temp, entry_avg_humidity,
    // entry_sessions, entry_sport_minutes
    output logic [127:0] m_axis_tdata,
    input  logic         i_cfg_we,
    input  logic         i_cfg_index,
    input  logic [7:0]   i_cfg_wdata
);

    typedef enum logic [2:0] {S_IDLE, S_OPEN, S_DIV1, S_DIV2, S_REPORT} t_state;

    t_state      r_state;
    t_entry      r_hist [HistDays];
    logic [CntW-1:0] r_count;
    logic [7:0]  r_hr_low, r_hr_high;
    logic [79:0] r_in;
    logic [1:0]  r_st;
    logic [127:0] r_out;
    logic        r_ovalid;
    logic        r_wait;
    logic        r_neg;
    t_div_req    n_div;
    logic        w_done;
    logic [24:0] w_quot;
    integer      k;

    logic [2:0]  w_req;
    logic [31:0] w_code;
    logic [7:0]  w_hr, w_temp;
    logic [6:0]  w_hum;
    logic [15:0] w_secs;
    logic [2:0]  w_ridx;
    logic        w_hr_ok;

    assign w_req  = r_in[2:0];
    assign w_code = {1'b0, r_in[9:3], 4'd0, r_in[13:10], 3'd0, r_in[18:14], 5'd0, r_in[21:19]};
    assign w_hr   = r_in[45:38];
    assign w_temp = r_in[53:46];
    assign w_hum  = r_in[60:54];
    assign w_secs = r_in[76:61];
    assign w_ridx = r_in[79:77];
    assign w_hr_ok = (w_hr >= r_hr_low) && (w_hr <= r_hr_high);

    // running-mean helpers on entry 0
    t_entry      e0;
    logic [15:0] w_n1;
    logic [24:0] w_hsum;
    logic [24:0] w_tmag;
    logic        w_tneg;
    logic signed [24:0] w_tsum;
    logic [16:0] w_mins;
    logic signed [10:0] w_tblend;
    logic [9:0]  w_hblend;
    logic [9:0]  w_hrblend;
    logic [7:0]  w_tq;

    assign e0 = r_hist[0];
    assign w_n1 = 16'(e0.env_cnt + 16'd1);
    assign w_tsum = 25'($signed(e0.mean_temp)) * $signed({9'd0, e0.env_cnt})
                    + 25'($signed(w_temp));
    assign w_tneg = w_tsum[24];
    assign w_tmag = w_tneg ? 25'(-w_tsum) : w_tsum;
    assign w_hsum = 25'(e0.avg_hum * e0.env_cnt) + 25'(w_hum);
    assign w_tblend = 11'($signed(e0.mean_temp)) * 11'sd3 + 11'($signed(w_temp));
    assign w_hblend = 10'(e0.avg_hum) * 10'd3 + 10'(w_hum);
    assign w_hrblend = 10'(e0.avg_hr) * 10'd3 + 10'(w_hr);
    // session minutes come from the divider quotient
    assign w_mins = 17'(e0.minutes) + w_quot[16:0];
    assign w_tq = w_tblend[10] ? 8'(-((-w_tblend) >>> 2)) : 8'(w_tblend >>> 2);

    always_comb begin
        n_div = '0;
        if (r_state == S_OPEN && !r_wait) begin
            if (w_req == REQ_HEART && w_hr_ok && e0.hr_cnt != 16'hFFFF) begin
                n_div.start    = 1'b1;
                n_div.dividend = 25'(e0.avg_hr * e0.hr_cnt) + 25'(w_hr);
                n_div.divisor  = 17'(e0.hr_cnt) + 17'd1;
            end else if (w_req == REQ_ENV && e0.env_cnt != 16'hFFFF) begin
                n_div.start    = 1'b1;
                n_div.dividend = w_tmag;
                n_div.divisor  = 17'(w_n1);
            end else if (w_req == REQ_SPORT) begin
                // seconds rounded up to whole minutes
                n_div.start    = 1'b1;
                n_div.dividend = 25'(w_secs) + 25'd59;
                n_div.divisor  = 17'd60;
            end
        end else if (r_state == S_DIV1 && w_done && w_req == REQ_ENV) begin
            n_div.start    = 1'b1;
            n_div.dividend = w_hsum;
            n_div.divisor  = 17'(w_n1);
        end
    end

    dhsh_divider u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (n_div),
        .o_done (w_done),
        .o_quot (w_quot)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_out;

    logic w_same;
    logic w_roll;
    assign w_same = (r_count != '0) && (e0.day_code[31:8] == w_code[31:8]);
    assign w_roll = (w_req <= REQ_SPORT) && (w_req != REQ_HEART || w_hr_ok) && !w_same;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_hr_low <= 8'd40;
            r_hr_high <= 8'd220;
            r_ovalid <= 1'b0;
            r_wait   <= 1'b0;
        end else begin
            // configuration writes
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_HR_LOW) r_hr_low <= i_cfg_wdata;
                else r_hr_high <= i_cfg_wdata;
            end
            if (r_ovalid && m_axis_tready) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_in    <= s_axis_tdata;
                        r_wait  <= 1'b1;
                        r_state <= S_OPEN;
                    end
                end
                S_OPEN: begin
                    if (r_wait) begin
                        // day roll step
                        r_wait <= 1'b0;
                        if (w_roll) begin
                            if (r_count != '0) begin
                                for (k = HistDays - 1; k > 0; k = k - 1)
                                    r_hist[k] <= r_hist[k-1];
                                if (r_count != CntW'(HistDays))
                                    r_count <= r_count + 1'b1;
                                r_st <= ST_ROLLED;
                            end else begin
                                r_count <= CntW'(1);
                                r_st    <= ST_INIT;
                            end
                            r_hist[0] <= '{day_code: w_code, default: '0};
                        end else begin
                            r_st <= ST_UNCHANGED;
                        end
                    end else begin
                        case (w_req)
                            REQ_STEPS: begin
                                r_hist[0].steps <= r_in[37:22];
                                r_state <= S_REPORT;
                            end
                            REQ_HEART: begin
                                if (w_hr_ok && e0.hr_cnt != 16'hFFFF) begin
                                    r_hist[0].hr_cnt <= e0.hr_cnt + 16'd1;
                                    r_state <= S_DIV2;
                                end else begin
                                    if (w_hr_ok) r_hist[0].avg_hr <= w_hrblend[9:2];
                                    r_state <= S_REPORT;
                                end
                                if (w_hr_ok && w_hr > e0.max_hr) r_hist[0].max_hr <= w_hr;
                            end
                            REQ_ENV: begin
                                if (e0.env_cnt != 16'hFFFF) begin
                                    r_neg   <= w_tneg;
                                    r_state <= S_DIV1;
                                end else begin
                                    r_hist[0].mean_temp <= w_tq;
                                    r_hist[0].avg_hum   <= w_hblend[9:2];
                                    r_state <= S_REPORT;
                                end
                            end
                            REQ_SPORT: begin
                                if (e0.sessions != 8'hFF)
                                    r_hist[0].sessions <= e0.sessions + 8'd1;
                                r_state <= S_DIV2;
                            end
                            default: r_state <= S_REPORT;
                        endcase
                    end
                end
                S_DIV1: begin
                    if (w_done) begin
                        r_hist[0].mean_temp <= r_neg ? 8'(-w_quot) : w_quot[7:0];
                        r_state <= S_DIV2;
                    end
                end
                S_DIV2: begin
                    if (w_done) begin
                        if (w_req == REQ_ENV) begin
                            r_hist[0].avg_hum <= w_quot[7:0];
                            r_hist[0].env_cnt <= w_n1;
                        end else if (w_req == REQ_SPORT) begin
                            r_hist[0].minutes <= w_mins[16] ? 16'hFFFF : w_mins[15:0];
                        end else begin
                            r_hist[0].avg_hr <= w_quot[7:0];
                        end
                        r_state <= S_REPORT;
                    end
                end
                S_REPORT: begin
                    if (!r_ovalid) begin
                        logic [IdxW-1:0] idx;
                        logic ok;
                        t_entry e;
                        idx = (w_req == REQ_READ) ? IdxW'(w_ridx) : '0;
                        ok  = ((w_req == REQ_READ) ? {1'b0, w_ridx} : 4'd0) < 4'(r_count);
                        e   = ok ? r_hist[idx] : '0;
                        r_out <= {1'b0, e.minutes, e.sessions, e.avg_hum, e.mean_temp,
                                  e.hr_cnt, e.max_hr, e.avg_hr, e.steps, e.day_code,
                                  ok, 4'(r_count), r_st};
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== sv/dhsh_checker.sv =====
module dhsh_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [127:0] m_axis_tdata
);

    // held result stays put while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed under stall");

    // count never exceeds depth
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[5:2] <= 4'd8)
        else $error("entry count out of range");

    // input closes right after an accepted transaction
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("accept while busy");

    // stalled result is not withdrawn
    a_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped under stall");

    // invalid entry reports zeros
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[6] |-> m_axis_tdata[126:7] == '0)
        else $error("invalid entry not zero");

endmodule

bind daily_health_summary_history_core dhsh_checker u_chk (.*);
